>>> rtl/etc_pkg.sv
// Shared types, constants and a helper function for the environmental sensor
// compensation unit. No dependencies; every rtl file imports this package.
package etc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TEMP_TRIM  = 3'd0,
        CFG_PRESS_LOW  = 3'd1,
        CFG_PRESS_HIGH = 3'd2,
        CFG_PRESS_LAST = 3'd3,
        CFG_HUM_TRIM   = 3'd4
    } t_cfg_idx;

    localparam int DIV_STAGES   = 64;
    localparam int FRONT_STAGES = 7;
    localparam int BACK_STAGES  = 11;

    // Temperature constants
    localparam logic [31:0] C_T_RND    = 32'd128;
    // Pressure constants
    localparam logic [32:0] C_P_TOFF   = 33'd128000;
    localparam logic [20:0] C_P_FULL   = 21'd1048576;
    localparam logic [11:0] C_P_SCALE  = 12'd3125;
    localparam logic [63:0] C_P_BIAS   = 64'h0000_8000_0000_0000;
    // Humidity constants
    localparam logic [31:0] C_H_TOFF   = 32'd76800;
    localparam logic [31:0] C_H_RND    = 32'd16384;
    localparam logic [31:0] C_H_HALF   = 32'd32768;
    localparam logic [31:0] C_H_BIAS   = 32'd2097152;
    localparam logic [31:0] C_H_RND2   = 32'd8192;
    localparam logic [31:0] C_H_MAX    = 32'd419430400;

    // Decoded trim words; signed fields are kept as raw bit patterns
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [11:0] h4;
        logic [11:0] h5;
        logic [7:0]  h6;
    } t_trim;

    // Values that ride alongside the pressure path
    typedef struct packed {
        logic [31:0] tf;
        logic [23:0] tc;
        logic [15:0] ah;
    } t_side;

    // One finished reading
    typedef struct packed {
        logic        inval;
        logic [16:0] hum;
        logic [31:0] pres;
        logic [23:0] tc;
        logic [31:0] tf;
    } t_result;

    // Low 64 bits of a 64-bit word times a signed 16-bit value
    function automatic logic [63:0] mul64x16s(input logic [63:0] a, input logic [15:0] b);
        logic [79:0] pr;
        pr = a * b;
        return pr[63:0] - (b[15] ? {a[47:0], 16'b0} : 64'd0);
    endfunction

endpackage

>>> rtl/etc_temp.sv
// Temperature stages: fine temperature and hundredths of a degree.
// Depends on etc_pkg.
module etc_temp import etc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [19:0] i_ap,
    input  logic [19:0] i_at,
    input  logic [15:0] i_ah,
    input  t_trim       i_trim,
    output logic        o_valid,
    output logic [19:0] o_ap,
    output t_side       o_side
);

    logic [3:0]  r_v;
    logic [31:0] r1_m1, r1_dd, r2_v1, r2_m2, r3_tf, r4_tf;
    logic [23:0] r4_tc;
    logic [19:0] r1_ap, r2_ap, r3_ap, r4_ap;
    logic [15:0] r1_ah, r2_ah, r3_ah, r4_ah;
    logic [31:0] n_dv1, n_d, n_t5;

    assign n_dv1 = {15'b0, i_at[19:3]} - {15'b0, i_trim.t1, 1'b0};
    assign n_d   = {16'b0, i_at[19:4]} - {16'b0, i_trim.t1};
    assign n_t5  = {r3_tf[29:0], 2'b0} + r3_tf + C_T_RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m1 <= n_dv1 * {{16{i_trim.t2[15]}}, i_trim.t2};
            r1_dd <= n_d * n_d;
            r1_ap <= i_ap;
            r1_ah <= i_ah;
            r2_v1 <= 32'($signed(r1_m1) >>> 11);
            r2_m2 <= 32'($signed(r1_dd) >>> 12) * {{16{i_trim.t3[15]}}, i_trim.t3};
            r2_ap <= r1_ap;
            r2_ah <= r1_ah;
            r3_tf <= r2_v1 + 32'($signed(r2_m2) >>> 14);
            r3_ap <= r2_ap;
            r3_ah <= r2_ah;
            r4_tf <= r3_tf;
            r4_tc <= n_t5[31:8];
            r4_ap <= r3_ap;
            r4_ah <= r3_ah;
        end
    end

    assign o_valid   = r_v[3];
    assign o_ap      = r4_ap;
    assign o_side.tf = r4_tf;
    assign o_side.tc = r4_tc;
    assign o_side.ah = r4_ah;

endmodule

>>> rtl/etc_pfront.sv
// Pressure front stages: trim polynomial, numerator and divisor, sign split.
// Depends on etc_pkg.
module etc_pfront import etc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [19:0] i_ap,
    input  t_side       i_side,
    input  t_trim       i_trim,
    output logic        o_valid,
    output logic [63:0] o_ua,
    output logic [30:0] o_ub,
    output logic        o_inval,
    output logic        o_neg,
    output t_side       o_side
);

    logic [FRONT_STAGES-1:0] r_v;
    t_side       r_side [FRONT_STAGES];
    logic [32:0] r1_q1;
    logic [19:0] r1_ap, r2_ap, r3_ap, r4_ap;
    logic [63:0] r2_sq, r3_a6, r3_a3, r4_q2, r4_q1b, r5_s47, r5_nb, r6_n, r7_ua;
    logic [48:0] r2_qp5, r2_qp2, r3_qp5, r3_qp2;
    logic [30:0] r6_d, r7_ub;
    logic        r7_inval, r7_neg;

    logic signed [65:0] n_sq;
    logic signed [48:0] n_qp5, n_qp2;
    logic [20:0] n_pv;
    logic [79:0] n_x;
    logic [75:0] n_n;

    assign n_sq  = $signed(r1_q1) * $signed(r1_q1);
    assign n_qp5 = $signed(r1_q1) * $signed(i_trim.p5);
    assign n_qp2 = $signed(r1_q1) * $signed(i_trim.p2);
    assign n_pv  = C_P_FULL - {1'b0, r4_ap};
    assign n_x   = r5_s47 * i_trim.p1;
    assign n_n   = r5_nb * C_P_SCALE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[FRONT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < FRONT_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r1_q1  <= {i_side.tf[31], i_side.tf} - C_P_TOFF;
            r1_ap  <= i_ap;
            r2_sq  <= n_sq[63:0];
            r2_qp5 <= n_qp5;
            r2_qp2 <= n_qp2;
            r2_ap  <= r1_ap;
            r3_a6  <= mul64x16s(r2_sq, i_trim.p6);
            r3_a3  <= mul64x16s(r2_sq, i_trim.p3);
            r3_qp5 <= r2_qp5;
            r3_qp2 <= r2_qp2;
            r3_ap  <= r2_ap;
            r4_q2  <= r3_a6 + {r3_qp5[46:0], 17'b0}
                    + {{13{i_trim.p4[15]}}, i_trim.p4, 35'b0};
            r4_q1b <= 64'($signed(r3_a3) >>> 8) + {{3{r3_qp2[48]}}, r3_qp2, 12'b0};
            r4_ap  <= r3_ap;
            r5_s47 <= r4_q1b + C_P_BIAS;
            r5_nb  <= {12'b0, n_pv, 31'b0} - r4_q2;
            r6_d   <= n_x[63:33];
            r6_n   <= n_n[63:0];
            r7_ua    <= r6_n[63] ? (64'd0 - r6_n) : r6_n;
            r7_ub    <= r6_d[30] ? (31'd0 - r6_d) : r6_d;
            r7_inval <= (r6_d == 31'd0);
            r7_neg   <= r6_n[63] ^ r6_d[30];
        end
    end

    assign o_valid = r_v[FRONT_STAGES-1];
    assign o_ua    = r7_ua;
    assign o_ub    = r7_ub;
    assign o_inval = r7_inval;
    assign o_neg   = r7_neg;
    assign o_side  = r_side[FRONT_STAGES-1];

endmodule

>>> rtl/etc_div.sv
// Pipelined restoring divider, one quotient bit per stage, 64 stages.
// Depends on etc_pkg.
module etc_div import etc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_ua,
    input  logic [30:0] i_ub,
    input  logic        i_inval,
    input  logic        i_neg,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [63:0] o_q,
    output logic        o_inval,
    output logic        o_neg,
    output t_side       o_side
);

    typedef struct packed {
        logic [30:0] rem;
        logic [63:0] nq;
        logic [30:0] ub;
        logic        inval;
        logic        neg;
        t_side       side;
    } t_dstep;

    logic [DIV_STAGES-1:0] r_v;
    t_dstep r_st [DIV_STAGES];
    t_dstep n_in;

    // Shift one numerator bit into the remainder, subtract when it fits
    function automatic t_dstep div_step(input t_dstep x);
        t_dstep      y;
        logic [31:0] t;
        logic        ge;
        y  = x;
        t  = {x.rem, x.nq[63]};
        ge = (t >= {1'b0, x.ub});
        y.rem = ge ? 31'(t - {1'b0, x.ub}) : t[30:0];
        y.nq  = {x.nq[62:0], ge};
        return y;
    endfunction

    always_comb begin
        n_in.rem   = '0;
        n_in.nq    = i_ua;
        n_in.ub    = i_ub;
        n_in.inval = i_inval;
        n_in.neg   = i_neg;
        n_in.side  = i_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= div_step(n_in);
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_st[k] <= div_step(r_st[k-1]);
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_q     = r_st[DIV_STAGES-1].nq;
    assign o_inval = r_st[DIV_STAGES-1].inval;
    assign o_neg   = r_st[DIV_STAGES-1].neg;
    assign o_side  = r_st[DIV_STAGES-1].side;

endmodule

>>> rtl/etc_back.sv
// Back stages: pressure correction after the divide and the humidity formula.
// Depends on etc_pkg.
module etc_back import etc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_q,
    input  logic        i_neg,
    input  logic        i_inval,
    input  t_side       i_side,
    input  t_trim       i_trim,
    output logic        o_valid,
    output t_result     o_res
);

    logic [BACK_STAGES-1:0] r_v;
    logic [BACK_STAGES-1:0] r_inv;
    t_side       r_side [BACK_STAGES];
    logic [31:0] r_pres [BACK_STAGES-5];

    // pressure path
    logic [63:0] r1_p, r2_p, r3_p, r4_p, r2_m9, r2_m8, r3_m8, r3_pp0, r4_m99, r4_q2c, r5_sum;
    logic [31:0] r3_pp1, r3_pp2;
    logic [63:0] n_ps1, n_ps2, n_sum;
    logic [31:0] n_pres;

    // humidity path
    logic [31:0] r1_x, r1_ka, r2_ka, r2_mh5, r2_mh6, r2_mh3;
    logic [31:0] r3_a, r3_b, r3_c, r4_a, r4_bc, r5_a, r5_e, r6_a, r6_eh, r7_a, r7_f;
    logic [31:0] r8_xx, r9_xx, r9_ss, r10_xx, r10_hm;
    logic [16:0] r11_hum;
    logic [31:0] n_s, n_y;
    logic [16:0] n_hum;

    assign n_ps1  = 64'($signed(r1_p) >>> 13);
    assign n_ps2  = 64'($signed(r2_p) >>> 13);
    assign n_sum  = r4_p + 64'($signed(r4_m99) >>> 25) + r4_q2c;
    assign n_pres = r_inv[4] ? 32'd0
                  : r5_sum[39:8] + {{12{i_trim.p7[15]}}, i_trim.p7, 4'b0};

    assign n_s = 32'($signed(r8_xx) >>> 15);
    assign n_y = r10_xx - 32'($signed(r10_hm) >>> 4);

    // Clamp to 0..100 %RH before dropping the low fraction bits
    always_comb begin
        if (n_y[31]) begin
            n_hum = '0;
        end else if (n_y > C_H_MAX) begin
            n_hum = C_H_MAX[28:12];
        end else begin
            n_hum = n_y[28:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[BACK_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_inv     <= {r_inv[BACK_STAGES-2:0], i_inval};
            for (int k = 1; k < BACK_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_pres[0] <= n_pres;
            for (int k = 1; k < BACK_STAGES - 5; k++) begin
                r_pres[k] <= r_pres[k-1];
            end

            r1_p   <= i_neg ? (64'd0 - i_q) : i_q;
            r2_p   <= r1_p;
            r2_m9  <= mul64x16s(n_ps1, i_trim.p9);
            r2_m8  <= mul64x16s(r1_p, i_trim.p8);
            r3_p   <= r2_p;
            r3_m8  <= r2_m8;
            r3_pp0 <= r2_m9[31:0] * n_ps2[31:0];
            r3_pp1 <= r2_m9[31:0] * n_ps2[63:32];
            r3_pp2 <= r2_m9[63:32] * n_ps2[31:0];
            r4_p   <= r3_p;
            r4_m99 <= r3_pp0 + {r3_pp1 + r3_pp2, 32'b0};
            r4_q2c <= 64'($signed(r3_m8) >>> 19);
            r5_sum <= n_sum;

            r1_x   <= i_side.tf - C_H_TOFF;
            r1_ka  <= {2'b0, i_side.ah, 14'b0} - {i_trim.h4, 20'b0} + C_H_RND;
            r2_ka  <= r1_ka;
            r2_mh5 <= r1_x * {{20{i_trim.h5[11]}}, i_trim.h5};
            r2_mh6 <= r1_x * {{24{i_trim.h6[7]}}, i_trim.h6};
            r2_mh3 <= r1_x * {24'b0, i_trim.h3};
            r3_a   <= 32'($signed(r2_ka - r2_mh5) >>> 15);
            r3_b   <= 32'($signed(r2_mh6) >>> 10);
            r3_c   <= 32'($signed(r2_mh3) >>> 11) + C_H_HALF;
            r4_a   <= r3_a;
            r4_bc  <= r3_b * r3_c;
            r5_a   <= r4_a;
            r5_e   <= 32'($signed(r4_bc) >>> 10) + C_H_BIAS;
            r6_a   <= r5_a;
            r6_eh  <= r5_e * {{16{i_trim.h2[15]}}, i_trim.h2};
            r7_a   <= r6_a;
            r7_f   <= 32'($signed(r6_eh + C_H_RND2) >>> 14);
            r8_xx  <= r7_a * r7_f;
            r9_xx  <= r8_xx;
            r9_ss  <= n_s * n_s;
            r10_xx <= r9_xx;
            r10_hm <= 32'($signed(r9_ss) >>> 7) * {24'b0, i_trim.h1};
            r11_hum <= n_hum;
        end
    end

    assign o_valid     = r_v[BACK_STAGES-1];
    assign o_res.inval = r_inv[BACK_STAGES-1];
    assign o_res.hum   = r11_hum;
    assign o_res.pres  = r_pres[BACK_STAGES-6];
    assign o_res.tc    = r_side[BACK_STAGES-1].tc;
    assign o_res.tf    = r_side[BACK_STAGES-1].tf;

endmodule

>>> rtl/env_sensor_compensation_unit.sv
// Top level of the environmental sensor compensation unit: trim registers,
// stream handshake and output buffer. Depends on etc_pkg and the etc_* stages.
//
// Usage:
//  - Write the trim words over the cfg channel (index 0 temperature trim,
//    1..3 pressure trims, 4 humidity trim) while no reading is in flight.
//    o_cfg_ready is always high; unknown indexes are dropped.
//  - Stream raw readings on the s channel, one transfer per reading. Every
//    reading gives exactly one result transfer on the m channel, in order.
//  - Throughput: one reading per clock while o_s_tready is high. The path from
//    the input transfer to o_m_tvalid is set by the 64-stage pressure divider
//    plus temperature, trim and correction stages around it and the output
//    register.
//  - A stalled receiver holds the result in the output register; the next
//    result from the pipeline goes to a skid register, and only when that
//    is full does the whole pipeline freeze and o_s_tready drop.
//  - Reset clears every valid bit and all trim words to zero.
module env_sensor_compensation_unit import etc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input readings
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [19:0] raw_pressure, [39:20] raw_temperature, [55:40] raw_humidity
    input  logic [55:0]  i_s_tdata,
    // results
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] fine_temperature, [55:32] temperature_centi, [87:56] pressure_q24_8,
    // [104:88] humidity_q7_10, [111:105] zero
    output logic [111:0] o_m_tdata,
    // [0] pressure_invalid
    output logic [0:0]   o_m_tuser,
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    logic [47:0] r_temp_trim;
    logic [63:0] r_press_low, r_press_high, r_hum_trim;
    logic [15:0] r_press_last;
    t_trim       n_trim;

    logic        r_out_v, r_skid_v;
    t_result     r_out, r_skid;
    logic        n_en;

    logic        tmp_v, pf_v, dv_v, bk_v;
    logic [19:0] tmp_ap;
    t_side       tmp_side, pf_side, dv_side;
    logic [63:0] pf_ua, dv_q;
    logic [30:0] pf_ub;
    logic        pf_inval, pf_neg, dv_inval, dv_neg;
    t_result     bk_res;

    // Trim registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim  <= '0;
            r_press_low  <= '0;
            r_press_high <= '0;
            r_press_last <= '0;
            r_hum_trim   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEMP_TRIM:  r_temp_trim  <= i_cfg_data[47:0];
                CFG_PRESS_LOW:  r_press_low  <= i_cfg_data;
                CFG_PRESS_HIGH: r_press_high <= i_cfg_data;
                CFG_PRESS_LAST: r_press_last <= i_cfg_data[15:0];
                CFG_HUM_TRIM:   r_hum_trim   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Split the trim words into coefficients
    always_comb begin
        n_trim.t1 = r_temp_trim[15:0];
        n_trim.t2 = r_temp_trim[31:16];
        n_trim.t3 = r_temp_trim[47:32];
        n_trim.p1 = r_press_low[15:0];
        n_trim.p2 = r_press_low[31:16];
        n_trim.p3 = r_press_low[47:32];
        n_trim.p4 = r_press_low[63:48];
        n_trim.p5 = r_press_high[15:0];
        n_trim.p6 = r_press_high[31:16];
        n_trim.p7 = r_press_high[47:32];
        n_trim.p8 = r_press_high[63:48];
        n_trim.p9 = r_press_last;
        n_trim.h1 = r_hum_trim[7:0];
        n_trim.h2 = r_hum_trim[23:8];
        n_trim.h3 = r_hum_trim[31:24];
        n_trim.h4 = r_hum_trim[43:32];
        n_trim.h5 = r_hum_trim[55:44];
        n_trim.h6 = r_hum_trim[63:56];
    end

    // The pipeline advances as long as the skid register is free
    assign n_en       = !r_skid_v;
    assign o_s_tready = n_en;

    etc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (i_s_tvalid),
        .i_ap    (i_s_tdata[19:0]),
        .i_at    (i_s_tdata[39:20]),
        .i_ah    (i_s_tdata[55:40]),
        .i_trim  (n_trim),
        .o_valid (tmp_v),
        .o_ap    (tmp_ap),
        .o_side  (tmp_side)
    );

    etc_pfront u_pfront (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (tmp_v),
        .i_ap    (tmp_ap),
        .i_side  (tmp_side),
        .i_trim  (n_trim),
        .o_valid (pf_v),
        .o_ua    (pf_ua),
        .o_ub    (pf_ub),
        .o_inval (pf_inval),
        .o_neg   (pf_neg),
        .o_side  (pf_side)
    );

    etc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (pf_v),
        .i_ua    (pf_ua),
        .i_ub    (pf_ub),
        .i_inval (pf_inval),
        .i_neg   (pf_neg),
        .i_side  (pf_side),
        .o_valid (dv_v),
        .o_q     (dv_q),
        .o_inval (dv_inval),
        .o_neg   (dv_neg),
        .o_side  (dv_side)
    );

    etc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (dv_v),
        .i_q     (dv_q),
        .i_neg   (dv_neg),
        .i_inval (dv_inval),
        .i_side  (dv_side),
        .i_trim  (n_trim),
        .o_valid (bk_v),
        .o_res   (bk_res)
    );

    // Output register plus skid: drain the skid first, otherwise take the
    // pipeline result into whichever register is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_m_tready) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || i_m_tready) begin
            r_out_v <= bk_v;
            r_out   <= bk_res;
        end else begin
            r_skid_v <= bk_v;
            r_skid   <= bk_res;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {7'b0, r_out.hum, r_out.pres, r_out.tc, r_out.tf};
    assign o_m_tuser  = r_out.inval;

endmodule
